// File: rtl/qte_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle block.
package qte_pkg;

	localparam int ME_W  = 36;  // rotation matrix entry
	localparam int XW    = 38;  // CORDIC x/y datapath
	localparam int ZW    = 34;  // CORDIC angle, scaled 2^29
	localparam int CW    = 32;  // acos argument, scaled 2^30, holds +1.0
	localparam int RTW   = 31;  // square root result
	localparam int SQIW  = 62;  // square root radicand
	localparam int QDEPTH = 8;
	localparam int QAW   = 3;
	localparam int QCW   = 4;

	localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(843314857);
	localparam int OUT_PI = 25736;

	localparam logic [1:0] CFG_FIRST_AXIS  = 2'd0;
	localparam logic [1:0] CFG_SECOND_NEXT = 2'd1;
	localparam logic [1:0] CFG_MARGIN      = 2'd2;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] angle_phi;
		logic [14:0]        angle_theta;
		logic signed [15:0] angle_psi;
	} euler_t;

	typedef struct packed {
		logic [1:0]  first_axis;
		logic        second_is_next;
		logic [14:0] gimbal_margin;
	} cfg_t;

	typedef struct packed {
		logic                   gimbal;
		logic signed [ME_W-1:0] phi_y;
		logic signed [ME_W-1:0] phi_x;
		logic signed [ME_W-1:0] psi_y;
		logic signed [ME_W-1:0] psi_x;
		logic signed [CW-1:0]   cos_c;
	} work_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           full;
		logic           push;
	} qstat_t;

	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] tab [10];
		tab[0] = ZW'(421657428);
		tab[1] = ZW'(248918915);
		tab[2] = ZW'(131521918);
		tab[3] = ZW'(66762579);
		tab[4] = ZW'(33510843);
		tab[5] = ZW'(16771758);
		tab[6] = ZW'(8387925);
		tab[7] = ZW'(4194219);
		tab[8] = ZW'(2097141);
		tab[9] = ZW'(1048575);
		if (i < 10)
			return tab[i];
		else if (i < 30)
			return ZW'(64'd536870912 >> i);
		else
			return '0;
	endfunction

endpackage

// File: rtl/qte_front.sv
// Front end: products, rotation matrix, axis selection and gimbal classification.
module qte_front import qte_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  quat_t quat,
	input  cfg_t  cfg,
	output logic  item_valid,
	output work_t item
);

	localparam int SC   = 2 * FRAC_BITS;
	localparam int LW   = 2 * FRAC_BITS + 18;
	localparam int CMW  = (LW > ME_W) ? LW : ME_W;
	localparam int DW   = (SC + 2 > ME_W) ? SC + 2 : ME_W;
	localparam int SHR  = (SC >= 30) ? SC - 30 : 0;
	localparam int SHL  = (SC < 30) ? 30 - SC : 0;

	logic                     v_s1, v_s2, v_s3;
	logic signed [31:0]       ww_s1, xx_s1, yy_s1, zz_s1, xy_s1;
	logic signed [31:0]       wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [ME_W-1:0]   m [3][3];
	logic [1:0]               ia, ib, ic;
	logic signed [ME_W-1:0]   diag_s2, ab_s2, ac_s2, ba_s2, ca_s2, bb_s2, cb_s2;
	logic signed [ME_W-1:0]   mag;
	logic signed [LW-1:0]     lim;
	logic signed [DW-1:0]     dd, dcl, one;
	logic                     pos;
	work_t                    work;
	work_t                    item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ww_s1 <= quat.quat_w * quat.quat_w;
		xx_s1 <= quat.quat_x * quat.quat_x;
		yy_s1 <= quat.quat_y * quat.quat_y;
		zz_s1 <= quat.quat_z * quat.quat_z;
		xy_s1 <= quat.quat_x * quat.quat_y;
		wz_s1 <= quat.quat_w * quat.quat_z;
		xz_s1 <= quat.quat_x * quat.quat_z;
		wy_s1 <= quat.quat_w * quat.quat_y;
		yz_s1 <= quat.quat_y * quat.quat_z;
		wx_s1 <= quat.quat_w * quat.quat_x;
	end

	always_comb begin
		m[0][0] = ME_W'(ww_s1) + ME_W'(xx_s1) - ME_W'(yy_s1) - ME_W'(zz_s1);
		m[0][1] = (ME_W'(xy_s1) - ME_W'(wz_s1)) <<< 1;
		m[0][2] = (ME_W'(xz_s1) + ME_W'(wy_s1)) <<< 1;
		m[1][0] = (ME_W'(xy_s1) + ME_W'(wz_s1)) <<< 1;
		m[1][1] = ME_W'(ww_s1) - ME_W'(xx_s1) + ME_W'(yy_s1) - ME_W'(zz_s1);
		m[1][2] = (ME_W'(yz_s1) - ME_W'(wx_s1)) <<< 1;
		m[2][0] = (ME_W'(xz_s1) - ME_W'(wy_s1)) <<< 1;
		m[2][1] = (ME_W'(yz_s1) + ME_W'(wx_s1)) <<< 1;
		m[2][2] = ME_W'(ww_s1) - ME_W'(xx_s1) - ME_W'(yy_s1) + ME_W'(zz_s1);
	end

	// axis zero acts as axis three
	assign pos = cfg.second_is_next;
	always_comb begin
		ia = (cfg.first_axis == 2'd0) ? 2'd2 : cfg.first_axis - 2'd1;
		if (pos) begin
			ib = (ia == 2'd2) ? 2'd0 : ia + 2'd1;
			ic = (ib == 2'd2) ? 2'd0 : ib + 2'd1;
		end else begin
			ib = (ia == 2'd0) ? 2'd2 : ia - 2'd1;
			ic = (ib == 2'd0) ? 2'd2 : ib - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		diag_s2 <= m[ia][ia];
		ab_s2   <= m[ia][ib];
		ac_s2   <= m[ia][ic];
		ba_s2   <= m[ib][ia];
		ca_s2   <= m[ic][ia];
		bb_s2   <= m[ib][ib];
		cb_s2   <= m[ic][ib];
	end

	always_comb begin
		mag = (diag_s2 < 0) ? -diag_s2 : diag_s2;
		lim = ((LW'(1) <<< FRAC_BITS) - LW'(cfg.gimbal_margin)) <<< FRAC_BITS;
		dd  = DW'(diag_s2);
		one = DW'(1) <<< SC;
		if (dd > one)
			dcl = one;
		else if (dd < -one)
			dcl = -one;
		else
			dcl = dd;
		work.gimbal = !(CMW'(mag) < CMW'(lim));
		work.cos_c  = CW'((dcl >>> SHR) <<< SHL);
		work.phi_y  = ab_s2;
		work.phi_x  = pos ? ac_s2 : -ac_s2;
		if (work.gimbal) begin
			work.psi_x = bb_s2;
			work.psi_y = pos ? cb_s2 : -cb_s2;
		end else begin
			work.psi_y = ba_s2;
			work.psi_x = pos ? -ca_s2 : ca_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s3 <= work;
	end

	assign item_valid = v_s3;
	assign item       = item_s3;

endmodule

// File: rtl/qte_queue.sv
// Short work queue between the front end and the angle back end.
module qte_queue import qte_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  work_t  din,
	input  logic   pop,
	output work_t  dout,
	output logic   dout_valid,
	output qstat_t stat
);

	work_t          mem [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] count_q;
	logic           do_pop;
	work_t          dout_q;
	logic           dvalid_q;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			count_q  <= '0;
			dvalid_q <= 1'b0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			count_q  <= count_q + QCW'(push) - QCW'(do_pop);
			dvalid_q <= do_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= din;
		if (do_pop)
			dout_q <= mem[rd_q];
	end

	assign dout       = dout_q;
	assign dout_valid = dvalid_q;
	assign stat.count = count_q;
	assign stat.full  = (count_q == QCW'(QDEPTH));
	assign stat.push  = push;

endmodule

// File: rtl/qte_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module qte_sqrt import qte_pkg::*; (
	input  logic            clk,
	input  logic [SQIW-1:0] v_in,
	output logic [RTW-1:0]  root
);

	localparam int RW = 35;

	logic [SQIW-1:0] v_s   [RTW+1];
	logic [RW-1:0]   rem_s [RTW+1];
	logic [RTW-1:0]  rt_s  [RTW+1];

	assign v_s[0]   = v_in;
	assign rem_s[0] = '0;
	assign rt_s[0]  = '0;

	for (genvar k = 0; k < RTW; k++) begin : g_stage
		logic [RW-1:0] r2, trial;
		always_comb begin
			r2    = {rem_s[k][RW-3:0], v_s[k][SQIW-1 -: 2]};
			trial = {(RW-2)'(rt_s[k]), 2'b01};
		end
		always_ff @(posedge clk) begin
			v_s[k+1] <= v_s[k] << 2;
			if (r2 >= trial) begin
				rem_s[k+1] <= r2 - trial;
				rt_s[k+1]  <= {rt_s[k][RTW-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= r2;
				rt_s[k+1]  <= {rt_s[k][RTW-2:0], 1'b0};
			end
		end
	end

	assign root = rt_s[RTW];

endmodule

// File: rtl/qte_cordic.sv
// Pipelined vectoring CORDIC atan2 with quadrant pre-rotation.
module qte_cordic import qte_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic                 clk,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [XW-1:0] x_in,
	output logic signed [ZW-1:0] z_out
);

	logic signed [XW-1:0] cx_s [STEPS+1];
	logic signed [XW-1:0] cy_s [STEPS+1];
	logic signed [ZW-1:0] cz_s [STEPS+1];
	logic                 zero_s [STEPS+1];

	always_ff @(posedge clk) begin
		zero_s[0] <= (x_in == '0) && (y_in == '0);
		if (x_in < 0) begin
			if (y_in >= 0) begin
				cx_s[0] <= y_in;
				cy_s[0] <= -x_in;
				cz_s[0] <= ANG_HALF_PI;
			end else begin
				cx_s[0] <= -y_in;
				cy_s[0] <= x_in;
				cz_s[0] <= -ANG_HALF_PI;
			end
		end else begin
			cx_s[0] <= x_in;
			cy_s[0] <= y_in;
			cz_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (cy_s[i] >= 0) begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + atan_step(i);
			end else begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - atan_step(i);
			end
		end
	end

	assign z_out = zero_s[STEPS] ? '0 : cz_s[STEPS];

endmodule

// File: rtl/qte_back.sv
// Back end: acos radicand, square root, three atan2 units and output rounding.
module qte_back import qte_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  work_t  item,
	output logic   done,
	output euler_t euler
);

	localparam int DL  = RTW + 1;
	localparam int LAT = DL + CORDIC_STEPS;

	logic signed [2*CW-1:0] csq_s1;
	work_t                  dly_s [DL];
	logic                   vld_s [LAT+1];
	logic [RTW-1:0]         root;
	logic [SQIW-1:0]        rad;
	logic                   gimbal_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0]   z_phi, z_theta, z_psi;
	logic signed [15:0]     r_phi, r_theta, r_psi;
	euler_t                 euler_q;
	logic                   done_q;

	function automatic logic signed [15:0] to_out(input logic signed [ZW-1:0] z);
		logic signed [ZW:0]    zr;
		logic signed [ZW-16:0] r;
		zr = (ZW+1)'(z) + (ZW+1)'(32768);
		r  = (ZW-15)'(zr >>> 16);
		if (r > (ZW-15)'(OUT_PI))
			return 16'(OUT_PI);
		else if (r < -(ZW-15)'(OUT_PI))
			return -16'(OUT_PI);
		else
			return 16'(r);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAT; i++)
				vld_s[i] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int i = 0; i < LAT; i++)
				vld_s[i+1] <= vld_s[i];
			done_q <= vld_s[LAT];
		end
	end

	always_ff @(posedge clk) begin
		csq_s1   <= item.cos_c * item.cos_c;
		dly_s[0] <= item;
		for (int i = 0; i < DL - 1; i++)
			dly_s[i+1] <= dly_s[i];
	end

	assign rad = (SQIW'(1) << 60) - SQIW'(csq_s1);

	qte_sqrt u_sqrt (
		.clk  (clk),
		.v_in (rad),
		.root (root)
	);

	// dly_s[DL-1] lines up with the square root output
	qte_cordic #(.STEPS(CORDIC_STEPS)) u_theta (
		.clk   (clk),
		.y_in  (XW'(root)),
		.x_in  (XW'(dly_s[DL-1].cos_c)),
		.z_out (z_theta)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_phi (
		.clk   (clk),
		.y_in  (XW'(dly_s[DL-1].phi_y)),
		.x_in  (XW'(dly_s[DL-1].phi_x)),
		.z_out (z_phi)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_psi (
		.clk   (clk),
		.y_in  (XW'(dly_s[DL-1].psi_y)),
		.x_in  (XW'(dly_s[DL-1].psi_x)),
		.z_out (z_psi)
	);

	always_ff @(posedge clk) begin
		gimbal_s[0] <= dly_s[DL-1].gimbal;
		for (int i = 0; i < CORDIC_STEPS; i++)
			gimbal_s[i+1] <= gimbal_s[i];
	end

	always_comb begin
		r_phi   = gimbal_s[CORDIC_STEPS] ? 16'sd0 : to_out(z_phi);
		r_theta = to_out(z_theta);
		r_psi   = to_out(z_psi);
	end

	always_ff @(posedge clk) begin
		euler_q.angle_phi   <= r_phi;
		euler_q.angle_theta <= (r_theta < 0) ? 15'd0 : r_theta[14:0];
		euler_q.angle_psi   <= r_psi;
	end

	assign done  = done_q;
	assign euler = euler_q;

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// Top level: quaternion to proper Euler angles with configurable axis sequence.
// Path from start to done: front end, work queue, radicand multiply, square root,
// CORDIC and output register. Throughput: one quaternion per cycle while busy
// is low; the pipelined CORDIC and root stages set it.
// Reset: arst_n clears the pipeline valid bits and the queue and sets the registers
// (first_axis 3, second_is_next 1, gimbal_margin 2); done is a one-cycle strobe.
module quaternion_to_euler_angles import qte_pkg::*; #(
	parameter int FRAC_BITS    = 14,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  quat_t       quat,
	output logic        done,
	output euler_t      euler,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	cfg_t   cfg_q;
	logic   accept;
	logic   item_valid;
	work_t  item;
	work_t  qout;
	logic   qvalid;
	qstat_t qstat;
	logic   pop;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign busy      = qstat.count >= QCW'(QDEPTH - 3);
	assign pop       = qstat.count != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_axis     <= 2'd3;
			cfg_q.second_is_next <= 1'b1;
			cfg_q.gimbal_margin  <= 15'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIRST_AXIS:  cfg_q.first_axis     <= cfg_data[1:0];
				CFG_SECOND_NEXT: cfg_q.second_is_next <= cfg_data[0];
				CFG_MARGIN:      cfg_q.gimbal_margin  <= cfg_data;
				default: ;
			endcase
		end
	end

	qte_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.quat       (quat),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item)
	);

	qte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (item_valid),
		.din        (item),
		.pop        (pop),
		.dout       (qout),
		.dout_valid (qvalid),
		.stat       (qstat)
	);

	qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qvalid),
		.item     (qout),
		.done     (done),
		.euler    (euler)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.push && qstat.full && !pop))
		else $error("work queue overflow");

	a_theta_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> euler.angle_theta <= 15'(OUT_PI))
		else $error("theta out of range");

	a_phi_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (euler.angle_phi <= 16'sd25736) && (euler.angle_phi >= -16'sd25736))
		else $error("phi out of range");

endmodule
